>>> rtl/stable_priority_queue_defines.svh
// Assertion macros of the stable priority queue, used by spq_datapath.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stable priority queue check failed");

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stable priority queue check failed");

`endif

>>> rtl/spq_pkg.sv
// Shared constants, types and command/status structs of the priority queue.
package spq_pkg;

  localparam int DEPTH    = 128;
  localparam int TAG_BITS = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Result status codes
  localparam logic [2:0] ST_INSERTED     = 3'd0;
  localparam logic [2:0] ST_UNRECOGNIZED = 3'd1;
  localparam logic [2:0] ST_FULL         = 3'd2;
  localparam logic [2:0] ST_SERVED       = 3'd3;
  localparam logic [2:0] ST_EMPTY        = 3'd4;

  // Read address selects
  localparam logic [1:0] RA_PTR_M1 = 2'd0;
  localparam logic [1:0] RA_PTR_M2 = 2'd1;
  localparam logic [1:0] RA_ZERO   = 2'd2;
  localparam logic [1:0] RA_PTR_P1 = 2'd3;

  // Write address selects
  localparam logic WA_PTR    = 1'b0;
  localparam logic WA_PTR_M1 = 1'b1;

  // Write data selects
  localparam logic WD_NEW = 1'b0;
  localparam logic WD_RD  = 1'b1;

  typedef struct packed {
    logic [1:0]          prio;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       ptr_dec;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic       wr_sel;
    logic       wd_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       capture;
    logic       emit;
    logic [2:0] status;
  } spq_cmd_t;

  typedef struct packed {
    logic is_call;
    logic sev_zero;
    logic full;
    logic empty;
    logic ptr_is_one;
    logic rd_lower;
    logic ptr_last;
  } spq_sts_t;

endpackage

>>> rtl/spq_ctrl.sv
// Sequencer of the priority queue: walks inserts and calls one entry a cycle.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_sts_t sts,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_HEAD   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.is_call) begin
          if (sts.sev_zero) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_UNRECOGNIZED;
            state_nxt  = S_IDLE;
          end else if (sts.full) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_FULL;
            state_nxt  = S_IDLE;
          end else if (sts.empty) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WA_PTR;
            cmd.wd_sel  = WD_NEW;
            cmd.cnt_inc = 1'b1;
            cmd.emit    = 1'b1;
            cmd.status  = ST_INSERTED;
            state_nxt   = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_PTR_M1;
            state_nxt  = S_SCAN;
          end
        end else begin
          if (sts.empty) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_EMPTY;
            state_nxt  = S_IDLE;
          end else begin
            cmd.ptr_clr = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RA_ZERO;
            state_nxt   = S_HEAD;
          end
        end
      end
      S_SCAN: begin
        if (sts.rd_lower) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WA_PTR;
          cmd.wd_sel  = WD_RD;
          cmd.ptr_dec = 1'b1;
          if (sts.ptr_is_one) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_PTR_M2;
          end
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WA_PTR;
          cmd.wd_sel  = WD_NEW;
          cmd.cnt_inc = 1'b1;
          cmd.emit    = 1'b1;
          cmd.status  = ST_INSERTED;
          state_nxt   = S_IDLE;
        end
      end
      S_PLACE: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WA_PTR;
        cmd.wd_sel  = WD_NEW;
        cmd.cnt_inc = 1'b1;
        cmd.emit    = 1'b1;
        cmd.status  = ST_INSERTED;
        state_nxt   = S_IDLE;
      end
      S_HEAD: begin
        cmd.capture = 1'b1;
        if (sts.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.emit    = 1'b1;
          cmd.status  = ST_SERVED;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RA_PTR_P1;
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_PTR_M1;
        cmd.wd_sel = WD_RD;
        if (sts.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.emit    = 1'b1;
          cmd.status  = ST_SERVED;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RA_PTR_P1;
          cmd.ptr_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/spq_datapath.sv
// Entry memory, count, walk pointer and result registers of the priority queue.
module spq_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_op,
  input  logic [1:0]        in_severity,
  input  logic [15:0]       in_tag,
  input  spq_pkg::spq_cmd_t cmd,
  output spq_pkg::spq_sts_t sts,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [15:0]       out_served_tag,
  output logic [1:0]        out_served_severity,
  output logic [7:0]        out_occupancy
);
  import spq_pkg::*;

  `include "stable_priority_queue_defines.svh"

  entry_t mem [DEPTH];
  entry_t rdata_r;
  entry_t wdata;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] ptr_m1, ptr_m2, ptr_p1;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  logic                op_r;
  logic [1:0]          sev_r;
  logic [TAG_BITS-1:0] tag_r;

  logic [TAG_BITS+15:0] tag_in_ext;
  logic [TAG_BITS+15:0] tag_out_ext;
  logic [CNT_W+7:0]     occ_ext;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_tag_r;
  logic [1:0]  out_sev_r;
  logic [7:0]  out_occ_r;

  assign ptr_m1 = ptr_r - CNT_W'(1);
  assign ptr_m2 = ptr_r - CNT_W'(2);
  assign ptr_p1 = ptr_r + CNT_W'(1);

  assign tag_in_ext  = {{TAG_BITS{1'b0}}, in_tag};
  assign tag_out_ext = {16'b0, rdata_r.tag};
  assign occ_ext     = {8'b0, cnt_nxt};

  always_comb begin
    case (cmd.rd_sel)
      RA_PTR_M1: rd_addr = ptr_m1[IDX_W-1:0];
      RA_PTR_M2: rd_addr = ptr_m2[IDX_W-1:0];
      RA_ZERO:   rd_addr = '0;
      RA_PTR_P1: rd_addr = ptr_p1[IDX_W-1:0];
      default:   rd_addr = '0;
    endcase
    wr_addr = (cmd.wr_sel == WA_PTR_M1) ? ptr_m1[IDX_W-1:0] : ptr_r[IDX_W-1:0];
    if (cmd.wd_sel == WD_RD) begin
      wdata = rdata_r;
    end else begin
      wdata.prio = sev_r;
      wdata.tag  = tag_r;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    ptr_nxt = ptr_r;
    if (cmd.load) begin
      ptr_nxt = cnt_r;
    end else if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_p1;
    end else if (cmd.ptr_dec) begin
      ptr_nxt = ptr_m1;
    end
  end

  always_comb begin
    sts.is_call    = op_r;
    sts.sev_zero   = (sev_r == 2'd0);
    sts.full       = (cnt_r == CNT_W'(DEPTH));
    sts.empty      = (cnt_r == '0);
    sts.ptr_is_one = (ptr_r == CNT_W'(1));
    sts.rd_lower   = (rdata_r.prio < sev_r);
    sts.ptr_last   = (ptr_r == cnt_r - CNT_W'(1));
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      op_r  <= in_op;
      sev_r <= in_severity;
      tag_r <= tag_in_ext[TAG_BITS-1:0];
    end
    if (cmd.capture) begin
      out_tag_r <= tag_out_ext[15:0];
      out_sev_r <= rdata_r.prio;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_occ_r    <= occ_ext[7:0];
      if (cmd.status != ST_SERVED) begin
        out_tag_r <= '0;
        out_sev_r <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_served_tag      = out_tag_r;
  assign out_served_severity = out_sev_r;
  assign out_occupancy       = out_occ_r;

  `SPQ_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `SPQ_ASSERT_IMP(a_no_overfill, clk, rst_n, cmd.cnt_inc, cnt_r < CNT_W'(DEPTH))
  `SPQ_ASSERT_IMP(a_no_underrun, clk, rst_n, cmd.cnt_dec, cnt_r != '0)
  `SPQ_ASSERT_IMP(a_port_apart, clk, rst_n, cmd.rd_en && cmd.wr_en, rd_addr != wr_addr)

endmodule

>>> rtl/stable_priority_queue.sv
// Top level of the stable priority queue: sequencer plus entry datapath.
//
// Usage:
//   Drive in_op, in_severity and in_tag and raise start; the request is a
//   transfer at the rising edge where start is high and busy is low.
//   in_op 0 inserts in_tag with priority in_severity (3 worst .. 1 regular);
//   the entry goes behind every entry of equal or higher priority, so equal
//   priorities leave in arrival order. Severity 0 is rejected, and so is an
//   insert into a full queue. in_op 1 removes and returns the front entry.
//   Each request yields exactly one result, shown on the out_ ports for one
//   cycle with out_valid high; the receiver cannot stall, so sample it then.
// Busy:
//   Each request is worked alone: an insert moves back every entry of
//   lower priority, and a call takes the front entry and shifts every other
//   entry one place toward the front; entries move one at a time through
//   the single-write, single-read entry memory. busy stays high meanwhile,
//   and a new request can be taken in the cycle its result is shown.
// Reset:
//   rst_n low (synchronous) empties the queue and drops any pending result;
//   entry storage itself is not cleared, since only held entries are read.
module stable_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [1:0]  in_severity,
  input  logic [15:0] in_tag,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_served_tag,
  output logic [1:0]  out_served_severity,
  output logic [7:0]  out_occupancy
);
  import spq_pkg::*;

  // Command and status traffic between sequencer and datapath.
  spq_cmd_t cmd;
  spq_sts_t sts;

  // Sequencer: latch the request, then walk the memory one entry a cycle.
  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath: hold entries, count and the one-cycle result strobe.
  spq_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_op               (in_op),
    .in_severity         (in_severity),
    .in_tag              (in_tag),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_served_tag      (out_served_tag),
    .out_served_severity (out_served_severity),
    .out_occupancy       (out_occupancy)
  );

endmodule
